>>> hdl/rfc_pkg.sv
// Shared types and constants for the reply frame checker.
// No dependencies; compiled first.
package rfc_pkg;

   // Input item opcodes
   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_BUSY   = 2'd0;
   localparam logic [1:0] ST_ACCEPT = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   // Configuration register indexes
   localparam logic CSR_DEVICE_ADDRESS    = 1'b0;
   localparam logic CSR_EXPECT_READ_REPLY = 1'b1;

   localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'h0A;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] device_address;
      logic       expect_read_reply;
   } cfg_type;

endpackage

>>> hdl/rfc_req_if.sv
// Input channel of the reply frame checker: one received byte or a clear.
// Depends on nothing.
interface rfc_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] rx_byte;

   modport source (output valid, opcode, rx_byte, input ready);
   modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

>>> hdl/rfc_rsp_if.sv
// Result channel of the reply frame checker: one status per input item.
// Depends on nothing.
interface rfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;

   modport source (output valid, status, input ready);
   modport sink   (input valid, status, output ready);
endinterface

>>> hdl/rfc_crc_byte.sv
// One-byte CRC-16/MODBUS update (reflected polynomial).
// Uses rfc_pkg for the polynomial.
module rfc_crc_byte (
   input  logic [15:0] crc_in,
   input  logic [7:0]  data,
   output logic [15:0] crc_out
);

   always_comb begin
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ rfc_pkg::CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      crc_out = crc;
   end

endmodule

>>> hdl/rfc_frame_ctl.sv
// Frame state (byte count, running CRC, received CRC low byte) and status decision.
// Uses rfc_pkg and rfc_crc_byte.
module rfc_frame_ctl #(
   parameter int PAYLOAD_BYTES = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  rfc_pkg::item_type item,
   input  rfc_pkg::cfg_type  cfg,
   output logic [1:0]        status
);

   localparam int CNT_W = $clog2(PAYLOAD_BYTES + 3);
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(PAYLOAD_BYTES + 2);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic [CNT_W-1:0] payload;
   logic [15:0]      crc_next;
   logic             crc_ok;

   rfc_crc_byte u_crc (
      .crc_in  (crc_ff),
      .data    (item.rx_byte),
      .crc_out (crc_next)
   );

   assign payload = CNT_W'(PAYLOAD_BYTES) + CNT_W'(cfg.expect_read_reply);
   assign crc_ok  = (crc_lo_ff == crc_ff[7:0]) && (item.rx_byte == crc_ff[15:8]);

   always_comb begin
      count_in  = count_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      status    = rfc_pkg::ST_BUSY;
      priority if (item.opcode == rfc_pkg::OP_CLEAR) begin
         count_in  = '0;
         crc_in    = rfc_pkg::CRC_INIT;
         crc_lo_in = '0;
      end else if (count_ff == '0 && item.rx_byte != cfg.device_address) begin
         // drop a stray first byte, keep waiting for the address
         status = rfc_pkg::ST_REJECT;
      end else if (count_ff < payload) begin
         crc_in   = crc_next;
         count_in = count_ff + 1'b1;
      end else if (count_ff == payload) begin
         crc_lo_in = item.rx_byte;
         count_in  = count_ff + 1'b1;
      end else begin
         // CRC high byte closes the frame
         status    = crc_ok ? rfc_pkg::ST_ACCEPT : rfc_pkg::ST_REJECT;
         count_in  = '0;
         crc_in    = rfc_pkg::CRC_INIT;
         crc_lo_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         crc_ff    <= rfc_pkg::CRC_INIT;
         crc_lo_ff <= '0;
      end else if (fire) begin
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("byte count out of range");

   a_clear_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && item.opcode == rfc_pkg::OP_CLEAR |=>
         count_ff == '0 && crc_ff == rfc_pkg::CRC_INIT)
      else $error("clear did not restart reception");

   a_accept_at_end: assert property (@(posedge clock) disable iff (reset)
      status == rfc_pkg::ST_ACCEPT |-> count_ff > payload)
      else $error("frame accepted before its CRC bytes");
`endif

endmodule

>>> hdl/rtu_reply_frame_checker_core.sv
// Top level of the reply frame checker: input register, configuration
// registers and result register around rfc_frame_ctl. Uses rfc_pkg and both channel interfaces.
//
//   channel   dir   handshake     payload
//   req_chan  in    valid/ready   opcode[0:0], rx_byte[7:0]
//   rsp_chan  out   valid/ready   status[1:0]
//   csr_*     in    csr_we        csr_index[0:0], csr_wdata[7:0]
//
// One item per cycle sustained while rsp_chan is not stalled; a result is valid once it is in the result register.
// The frame state updates as an item moves from the input register into the result register.
// A stalled result holds the result register; the input register still takes one more item.
// Synchronous reset restarts the frame state, clears both valid flags and resets the configuration registers.
module rtu_reply_frame_checker_core #(
   parameter int PAYLOAD_BYTES = 6
) (
   input  logic       clock,
   input  logic       reset,
   rfc_req_if.sink    req_chan,
   rfc_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   rfc_pkg::item_type item_ff;
   logic              item_valid_ff, item_valid_in;
   rfc_pkg::cfg_type  cfg_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        status_ff;
   logic [1:0]        status;
   logic              advance;
   logic              fire;
   logic              take;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign fire    = item_valid_ff && advance;
   assign req_chan.ready = !item_valid_ff || advance;
   assign take    = req_chan.valid && req_chan.ready;

   assign item_valid_in = take || (item_valid_ff && !fire);
   assign rsp_valid_in  = advance ? item_valid_ff : rsp_valid_ff;

   rfc_frame_ctl #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_frame_ctl (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .status (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (take) begin
         item_ff.opcode  <= req_chan.opcode;
         item_ff.rx_byte <= req_chan.rx_byte;
      end
      if (fire) begin
         status_ff <= status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address    <= rfc_pkg::DEVICE_ADDRESS_RESET;
         cfg_ff.expect_read_reply <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            rfc_pkg::CSR_DEVICE_ADDRESS:    cfg_ff.device_address    <= csr_wdata;
            rfc_pkg::CSR_EXPECT_READ_REPLY: cfg_ff.expect_read_reply <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = status_ff;

`ifndef SYNTHESIS
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> item_valid_ff && rsp_valid_ff && !rsp_chan.ready)
      else $error("input stalled while a stage was free");
`endif

endmodule
